// File: src/pbpm_pkg.sv
// Shared types and codes for the page buffer pool manager.
// Used by the controller, datapath and top level; no dependencies.
package pbpm_pkg;

  // request kinds
  typedef enum logic [3:0] {
    K_ALLOC   = 4'd0,
    K_SPECIAL = 4'd1,
    K_DIRTY   = 4'd2,
    K_FLUSH   = 4'd3,
    K_SYNC    = 4'd4,
    K_RELEASE = 4'd5,
    K_INCR    = 4'd6,
    K_DECR    = 4'd7,
    K_RESET   = 4'd8,
    K_QUERY   = 4'd9
  } kind_t;

  // result status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_FREE       = 2'd1;
  localparam logic [1:0] ST_RO_DIRTY      = 2'd2;
  localparam logic [1:0] ST_SPECIAL_DIRTY = 2'd3;

  localparam logic [15:0] REF_MAX = 16'hFFFF;

  // one slot of the tag table
  typedef struct packed {
    logic [31:0] rel;
    logic [31:0] blk;
    logic [15:0] cnt;
    logic        dirty;
  } ent_t;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_DISP, S_RD, S_CHK, S_FIN} state_t;
  typedef enum logic [2:0] {P_HIT, P_VICT, P_ONE, P_SYNC, P_RST} phase_t;

  typedef enum logic [2:0] {IX_HOLD, IX_ZERO, IX_ONE, IX_SLOT, IX_VICT, IX_INC} idx_op_t;
  typedef enum logic [2:0] {W_ZERO, W_HIT, W_VICT, W_ONE, W_SYNC, W_RST} wsel_t;
  typedef enum logic [2:0] {E_HIT, E_VICT, E_ONE, E_SYNC, E_NOFREE, E_DONE, E_RANGE} esel_t;
  typedef enum logic [1:0] {NV_HOLD, NV_VICT, NV_ONE} nv_op_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    we;
    wsel_t   wsel;
    logic    emit;
    esel_t   esel;
    nv_op_t  nv_op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  range_bad;
    logic  is_match;
    logic  is_free;
    logic  sync_emit;
    logic  idx_last;
    logic  cnt_last;
    logic  out_free;
  } stat_t;

endpackage

// File: src/pbpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: src/pbpm_ctrl.sv
// Controller state machine: sequences tag scans, victim search and sweeps.
// Depends on pbpm_pkg; drives the datapath through cmd_t, reads stat_t.
module pbpm_ctrl
  import pbpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  esel_t  fin_r, fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= P_ONE;
      fin_r   <= E_DONE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    cmd         = '0;
    cmd.idx_op  = IX_HOLD;
    cmd.wsel    = W_ZERO;
    cmd.esel    = E_DONE;
    cmd.nv_op   = NV_HOLD;
    unique case (state_r)
      // clearing pass after reset
      S_CLR: begin
        cmd.we   = 1'b1;
        cmd.wsel = W_ZERO;
        if (st.idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_op = IX_INC;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.cnt_clr = 1'b1;
        unique case (st.kind)
          K_ALLOC: begin
            cmd.idx_op = IX_ONE;
            phase_nxt  = P_HIT;
            state_nxt  = S_RD;
          end
          K_SPECIAL: begin
            cmd.idx_op = IX_ZERO;
            phase_nxt  = P_ONE;
            state_nxt  = S_RD;
          end
          K_SYNC: begin
            cmd.idx_op = IX_ZERO;
            phase_nxt  = P_SYNC;
            state_nxt  = S_RD;
          end
          K_RESET: begin
            cmd.idx_op = IX_ZERO;
            phase_nxt  = P_RST;
            state_nxt  = S_RD;
          end
          K_DIRTY, K_FLUSH, K_RELEASE, K_INCR, K_DECR, K_QUERY: begin
            if (st.range_bad) begin
              fin_nxt   = E_RANGE;
              state_nxt = S_FIN;
            end else begin
              cmd.idx_op = IX_SLOT;
              phase_nxt  = P_ONE;
              state_nxt  = S_RD;
            end
          end
          default: begin
            fin_nxt   = E_DONE;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        unique case (phase_r)
          P_HIT: begin
            if (st.is_match) begin
              if (st.out_free) begin
                cmd.we    = 1'b1;
                cmd.wsel  = W_HIT;
                cmd.emit  = 1'b1;
                cmd.esel  = E_HIT;
                state_nxt = S_IDLE;
              end
            end else if (st.idx_last) begin
              cmd.idx_op  = IX_VICT;
              cmd.cnt_clr = 1'b1;
              phase_nxt   = P_VICT;
              state_nxt   = S_RD;
            end else begin
              cmd.idx_op = IX_INC;
              state_nxt  = S_RD;
            end
          end
          P_VICT: begin
            if (st.is_free) begin
              if (st.out_free) begin
                cmd.we    = 1'b1;
                cmd.wsel  = W_VICT;
                cmd.emit  = 1'b1;
                cmd.esel  = E_VICT;
                cmd.nv_op = NV_VICT;
                state_nxt = S_IDLE;
              end
            end else if (st.cnt_last) begin
              fin_nxt   = E_NOFREE;
              state_nxt = S_FIN;
            end else begin
              cmd.idx_op  = IX_INC;
              cmd.cnt_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          P_ONE: begin
            if (st.out_free) begin
              cmd.we    = 1'b1;
              cmd.wsel  = W_ONE;
              cmd.emit  = 1'b1;
              cmd.esel  = E_ONE;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // sync and pool reset sweeps
            if (!(phase_r == P_SYNC && st.sync_emit && !st.out_free)) begin
              cmd.we   = 1'b1;
              cmd.wsel = (phase_r == P_SYNC) ? W_SYNC : W_RST;
              if (phase_r == P_SYNC && st.sync_emit) begin
                cmd.emit = 1'b1;
                cmd.esel = E_SYNC;
              end
              if (st.idx_last) begin
                cmd.nv_op = NV_ONE;
                fin_nxt   = E_DONE;
                state_nxt = S_FIN;
              end else begin
                cmd.idx_op = IX_INC;
                state_nxt  = S_RD;
              end
            end
          end
        endcase
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.esel  = fin_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/pbpm_dp.sv
// Datapath: request registers, tag table RAM, slot index, victim pointer,
// write-back counter and output word register. Depends on pbpm_pkg, pbpm_ram.
module pbpm_dp
  import pbpm_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output stat_t        st,
  input  logic [3:0]   in_kind,
  input  logic [70:0]  in_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_data,
  output logic [1:0]   out_status,
  output logic         out_last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int EW = $bits(ent_t);
  localparam logic [IW-1:0] IDX_MAX = IW'(NUM_SLOTS - 1);

  // request registers
  logic [3:0]  kind_r;
  logic [31:0] rel_r, blk_r;
  logic [5:0]  slot_r;
  logic        ra_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      rel_r  <= in_data[31:0];
      blk_r  <= in_data[63:32];
      slot_r <= in_data[69:64];
      ra_r   <= in_data[70];
    end
  end

  // index, try counter, victim pointer, write-back total
  logic [IW-1:0] idx_r, idx_nxt, cnt_r, nv_r, idx_inc;
  logic [31:0]   flush_r, flush_nxt;
  logic          flush_inc;

  assign idx_inc = (idx_r == IDX_MAX) ? '0 : idx_r + IW'(1);

  always_comb begin
    unique case (cmd.idx_op)
      IX_ZERO: idx_nxt = '0;
      IX_ONE:  idx_nxt = IW'(1);
      IX_SLOT: idx_nxt = IW'(slot_r);
      IX_VICT: idx_nxt = nv_r;
      IX_INC:  idx_nxt = idx_inc;
      default: idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      cnt_r   <= '0;
      nv_r    <= '0;
      flush_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IW'(1);
      end
      unique case (cmd.nv_op)
        NV_VICT: nv_r <= idx_inc;
        NV_ONE:  nv_r <= IW'(1);
        default: nv_r <= nv_r;
      endcase
      flush_r <= flush_nxt;
    end
  end

  // tag table
  logic [EW-1:0] rdata;
  ent_t          ent, wdata, one_ent, new_ent;
  logic          we_eff, one_err;
  logic [15:0]   up, dn;
  logic [1:0]    one_status;

  pbpm_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_ram (
    .clk     (clk),
    .we      (we_eff),
    .waddr   (idx_r),
    .wdata   (wdata),
    .raddr   (idx_r),
    .rdata_r (rdata)
  );

  assign ent = ent_t'(rdata);
  assign up  = (ent.cnt == REF_MAX) ? ent.cnt : ent.cnt + 16'd1;
  assign dn  = (ent.cnt == 16'd0) ? ent.cnt : ent.cnt - 16'd1;

  // single-slot operations
  always_comb begin
    new_ent    = ent;
    one_err    = 1'b0;
    one_status = ST_OK;
    unique case (kind_t'(kind_r))
      K_SPECIAL: begin
        one_err    = ent.dirty;
        one_status = ent.dirty ? ST_SPECIAL_DIRTY : ST_OK;
        new_ent    = '{rel: rel_r, blk: blk_r, cnt: up, dirty: 1'b0};
      end
      K_DIRTY: begin
        one_err    = (idx_r == '0);
        one_status = (idx_r == '0) ? ST_RO_DIRTY : ST_OK;
        new_ent.dirty = 1'b1;
        new_ent.cnt   = ra_r ? dn : ent.cnt;
      end
      K_FLUSH: begin
        new_ent.dirty = 1'b0;
        new_ent.cnt   = dn;
      end
      K_RELEASE: begin
        new_ent.dirty = 1'b0;
        new_ent.cnt   = '0;
        new_ent.rel   = '0;
      end
      K_INCR:  new_ent.cnt = up;
      K_DECR:  new_ent.cnt = dn;
      default: new_ent = ent;
    endcase
    one_ent = one_err ? ent : new_ent;
  end

  // write data selection
  always_comb begin
    wdata = ent;
    unique case (cmd.wsel)
      W_ZERO:  wdata = '0;
      W_HIT:   wdata.cnt = up;
      W_VICT:  wdata = '{rel: rel_r, blk: blk_r, cnt: 16'd1, dirty: 1'b0};
      W_ONE:   wdata = one_ent;
      W_SYNC: begin
        wdata.cnt = '0;
        if (st.sync_emit) begin
          wdata.rel   = '0;
          wdata.dirty = 1'b0;
        end
      end
      default: begin
        wdata.rel   = '0;
        wdata.dirty = 1'b0;
        wdata.cnt   = '0;
      end
    endcase
  end

  assign we_eff = cmd.we && !(cmd.wsel == W_ONE && one_err);

  // status to controller
  logic out_valid_r;

  always_comb begin
    st.kind      = kind_t'(kind_r);
    st.range_bad = (32'(slot_r) >= NUM_SLOTS);
    st.is_match  = (ent.rel != '0) && (ent.rel == rel_r) && (ent.blk == blk_r);
    st.is_free   = (idx_r != '0) && (ent.cnt == '0);
    st.sync_emit = (idx_r != '0) && ent.dirty;
    st.idx_last  = (idx_r == IDX_MAX);
    st.cnt_last  = (cnt_r == IDX_MAX);
    st.out_free  = !out_valid_r || out_tready;
  end

  // result word selection
  logic [1:0]  o_status;
  logic        o_hit, o_wb, o_last;
  logic [5:0]  o_slot;
  logic [31:0] o_wrel, o_wblk;
  logic [15:0] o_ref;

  always_comb begin
    o_status  = ST_OK;
    o_hit     = 1'b0;
    o_slot    = 6'(idx_r);
    o_wb      = 1'b0;
    o_wrel    = '0;
    o_wblk    = '0;
    o_ref     = '0;
    o_last    = 1'b1;
    flush_inc = 1'b0;
    unique case (cmd.esel)
      E_HIT: begin
        o_hit = 1'b1;
        o_ref = up;
      end
      E_VICT: begin
        o_wb      = ent.dirty;
        o_wrel    = ent.dirty ? ent.rel : '0;
        o_wblk    = ent.dirty ? ent.blk : '0;
        o_ref     = 16'd1;
        flush_inc = ent.dirty;
      end
      E_ONE: begin
        o_status = one_status;
        o_ref    = one_ent.cnt;
        if (kind_t'(kind_r) == K_FLUSH) begin
          o_wb      = 1'b1;
          o_wrel    = ent.rel;
          o_wblk    = ent.blk;
          flush_inc = 1'b1;
        end
      end
      E_SYNC: begin
        o_wb      = 1'b1;
        o_wrel    = ent.rel;
        o_wblk    = ent.blk;
        o_last    = 1'b0;
        flush_inc = 1'b1;
      end
      E_NOFREE: begin
        o_status = ST_NO_FREE;
        o_slot   = '0;
      end
      E_RANGE: o_slot = slot_r;
      default: o_slot = '0;
    endcase
  end

  assign flush_nxt = flush_r + 32'(cmd.emit && flush_inc);

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data   <= {flush_nxt, o_ref, o_wblk, o_wrel, o_wb, o_slot, o_hit};
      out_status <= o_status;
      out_last   <= o_last;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result emitted over an untaken word");
  a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.emit |=> $stable(flush_r))
    else $error("write-back total moved without a result");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r || !cmd.emit)
    else $error("request load collided with result emit");
`endif

endmodule

// File: src/page_buffer_pool_manager_top.sv
// Page buffer pool manager: tag table with round-robin replacement.
// Channels: in_* carries one request word (kind in in_tuser; rel_id, block_num,
// slot and release_after in in_tdata). out_* carries result words (status in
// out_tuser, out_tlast set on the final result of a request).
// After reset a clearing pass writes all NUM_SLOTS table entries, one per cycle,
// with in_tready low until the pass ends.
// Sequencing: each slot visit is a RAM read state, then a check/write state, on
// the tag RAM, whose read and write ports share the slot index. Slot requests
// visit one slot; allocate searches the tags of slots 1 to NUM_SLOTS-1, then up
// to NUM_SLOTS slots from the victim pointer for a victim; sync and pool reset
// sweep all slots, then give a done result. One request is in work at a time;
// the next is taken once the last result has been placed in the output register.
// When the receiver stalls, the result is held in the output register and the
// sweep waits on it; a new request can be accepted while the final result
// still waits to be taken.
// Depends on pbpm_pkg, pbpm_ctrl, pbpm_dp, pbpm_ram.
module page_buffer_pool_manager_top
  import pbpm_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // rel_id[31:0], block_num[63:32], slot[69:64],
                                   // release_after[70], zero[71]
  input  logic [3:0]   in_tuser,   // kind[3:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // hit[0], result_slot[6:1], writeback[7],
                                   // wb_rel_id[39:8], wb_block[71:40],
                                   // ref_now[87:72], flushes_done[119:88]
  output logic [1:0]   out_tuser,  // status[1:0]
  output logic         out_tlast
);

  cmd_t  cmd;
  stat_t st;

  pbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pbpm_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_kind    (in_tuser),
    .in_data    (in_tdata[70:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
